>>> rtl/core/tefc_pkg.sv
// Package for the tensor element format converter.
// Holds the mode codes and shared widths; no dependencies.
package tefc_pkg;

    typedef enum logic [2:0] {
        MODE_HALF   = 3'd0,
        MODE_BF16   = 3'd1,
        MODE_INT8   = 3'd2,
        MODE_UINT8  = 3'd3,
        MODE_PASS   = 3'd4,
        MODE_NARROW = 3'd5
    } mode_t;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

endpackage

>>> rtl/core/tefc_normalize.sv
// Normalizes a nonzero 10-bit magnitude: leading-one position and aligned fraction.
// Does not depend on tefc_pkg; purely combinational.
module tefc_normalize
(
    input  logic [9:0]  mag,
    output logic [3:0]  top,
    output logic [22:0] frac
);

    logic [32:0] shifted;

    always_comb
    begin
        top = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (mag[i])
            begin
                top = 4'(i);
            end
        end
        shifted = {23'd0, mag} << (5'd23 - {1'b0, top});
        frac = shifted[22:0];
    end

endmodule

>>> rtl/core/tefc_convert.sv
// Combinational conversion of one element according to the mode.
// Depends on tefc_pkg and tefc_normalize.
module tefc_convert
(
    input  tefc_pkg::mode_t mode,
    input  tefc_pkg::word_t x,
    output tefc_pkg::word_t r
);

    logic [9:0]  mag;
    logic [3:0]  top;
    logic [22:0] frac;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [7:0]  b;
    logic [7:0]  bmag;
    logic [8:0]  ne;

    tefc_normalize u_norm
    (
        .mag  (mag),
        .top  (top),
        .frac (frac)
    );

    always_comb
    begin
        he   = x[14:10];
        hm   = x[9:0];
        b    = x[7:0];
        bmag = (mode == tefc_pkg::MODE_INT8 && b[7]) ? 8'(~b + 8'd1) : b;
        // A byte of 0x80 gives magnitude 128, still within the 10-bit normalizer.
        mag  = (mode == tefc_pkg::MODE_HALF) ? hm :
               ((mode == tefc_pkg::MODE_INT8 && b == 8'h80) ? 10'd128 : {2'b00, bmag});
        ne   = {1'b0, x[30:23]} - 9'd112;
        r    = '0;
        unique case (mode) inside
            tefc_pkg::MODE_HALF:
            begin
                if (he == 5'h1f)
                begin
                    r = (hm != 10'd0) ? 32'h7FC00000 : {x[15], 31'h7F800000};
                end
                else if (he != 5'd0)
                begin
                    r = {x[15], 8'({3'd0, he} + 8'd112), hm, 13'd0};
                end
                else if (hm == 10'd0)
                begin
                    r = {x[15], 31'd0};
                end
                else
                begin
                    r = {x[15], 8'({4'd0, top} + 8'd103), frac};
                end
            end
            tefc_pkg::MODE_BF16:
            begin
                r = {x[15:0], 16'd0};
            end
            tefc_pkg::MODE_INT8, tefc_pkg::MODE_UINT8:
            begin
                if (b != 8'd0)
                begin
                    r = {(mode == tefc_pkg::MODE_INT8) & b[7],
                         8'({4'd0, top} + 8'd127), frac};
                end
            end
            tefc_pkg::MODE_PASS:
            begin
                r = x;
            end
            tefc_pkg::MODE_NARROW:
            begin
                if (x[30:23] <= 8'd112)
                begin
                    r = {16'd0, x[31], 15'd0};
                end
                else if (x[30:23] >= 8'd143)
                begin
                    r = {16'd0, x[31], 15'h7C00};
                end
                else
                begin
                    r = {16'd0, x[31], ne[4:0], x[22:13]};
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/tensor_element_format_converter_top.sv
// Top level of the tensor element format converter.
// Depends on tefc_pkg and tefc_convert.
//
// One element is taken per clock when start is high; busy is always low, so
// a request is never refused. The result appears on result_bits with done
// high after the input, then the result register; the receiver cannot
// stall it. cfg_ready is always high; the user writes format_mode through
// cfg_valid only while no request is in flight; the block does not enforce it.
module tensor_element_format_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] raw_bits,
    output logic        done,
    output logic [31:0] result_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    tefc_pkg::mode_t mode_reg;
    tefc_pkg::word_t in_reg;
    logic            in_vld_reg;
    tefc_pkg::word_t res_reg;
    logic            done_reg;
    tefc_pkg::word_t res_next;

    assign busy        = 1'b0;
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign result_bits = res_reg;

    tefc_convert u_conv
    (
        .mode (mode_reg),
        .x    (in_reg),
        .r    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= tefc_pkg::MODE_HALF;
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= tefc_pkg::mode_t'(cfg_data);
            end
            in_vld_reg <= start && !busy;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= raw_bits;
        end
        if (in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done) else $error("result strobe missing");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2)) else $error("result strobe without request");
    a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode_reg) == tefc_pkg::MODE_NARROW) |-> result_bits[31:16] == 16'd0)
        else $error("narrowed result has upper bits set");

endmodule
